// ===== sv/ppi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plane-plane intersection package
// Fixed-point formats, derived widths and the transfer payload types.
// ----------------------------------------------------------------------------
package ppi_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Cross products of two inputs, and their magnitudes.
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int U_W    = PROD_W + 1;
  localparam int MAG_W  = PROD_W;
  localparam int HALF_W = MAG_W / 2;
  // Products of two magnitudes.
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SP_W   = SQ_W + 1;
  // Point numerator, squared length and divider datapath.
  localparam int PN_W   = SQ_W + 3;
  localparam int DEN_W  = SQ_W + 2;
  localparam int NUM_W  = PN_W + FRAC_BITS;
  localparam int QBITS  = DATA_WIDTH + 1;
  localparam int REM_W  = DEN_W + QBITS + 1;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] plane1_nx;
    logic signed [DATA_WIDTH-1:0] plane1_ny;
    logic signed [DATA_WIDTH-1:0] plane1_nz;
    logic signed [DATA_WIDTH-1:0] plane1_offset;
    logic signed [DATA_WIDTH-1:0] plane2_nx;
    logic signed [DATA_WIDTH-1:0] plane2_ny;
    logic signed [DATA_WIDTH-1:0] plane2_nz;
    logic signed [DATA_WIDTH-1:0] plane2_offset;
  } ppi_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] line_dir_x;
    logic signed [DATA_WIDTH-1:0] line_dir_y;
    logic signed [DATA_WIDTH-1:0] line_dir_z;
    logic signed [DATA_WIDTH-1:0] line_point_x;
    logic signed [DATA_WIDTH-1:0] line_point_y;
    logic signed [DATA_WIDTH-1:0] line_point_z;
    logic                         planes_parallel;
  } ppi_out_t;

endpackage

// ===== sv/plane_plane_intersection_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plane-plane intersection core
// Line of intersection of two planes in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one plane pair per transfer; out_valid/
//   out_stall/out_data carry one line per transfer, in input order.
//   The pipe holds 43 registers: eight arithmetic stages (products, cross
//   products, 64 by 64 multiplies built from 32 by 32 partial products, sums
//   and magnitudes), one overflow check, a 33-stage restoring divider giving
//   one quotient bit per stage, and the output register. Throughput is one
//   pair per cycle while in_stall is low. Each stage moves on when it is
//   empty or its successor moves, so a stalled output only holds the stages
//   that are full behind it; empty stages keep taking new pairs until the
//   pipe has filled up.
//   Parallel normals give planes_parallel high with a zero direction and
//   point. Results saturate to 32 bits.
//   Reset clears every stage valid bit; no result is presented until the
//   first pair has passed through.
// ----------------------------------------------------------------------------
module plane_plane_intersection_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ppi_pkg::ppi_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ppi_pkg::ppi_out_t  out_data
);

  localparam int DW       = ppi_pkg::DATA_WIDTH;
  localparam int DIV_BASE = 8;
  localparam int OUT_IDX  = DIV_BASE + ppi_pkg::QBITS + 1;
  localparam int NST      = OUT_IDX + 1;

  typedef struct packed {
    logic signed [ppi_pkg::PROD_W-1:0] pa;
    logic signed [ppi_pkg::PROD_W-1:0] pb;
  } pair_t;

  typedef struct packed {
    logic [ppi_pkg::REM_W-1:0] rem;
    logic [ppi_pkg::QBITS-1:0] q;
    logic                      neg;
    logic                      ovf;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [2:0]               lane;
    logic [ppi_pkg::DEN_W-1:0]     den;
    logic                          par;
    logic [2:0][DW-1:0]            dir;
  } div_stage_t;

  // Saturates u >>> FRAC_BITS to the output width.
  function automatic logic [DW-1:0] sat_dir(input logic signed [ppi_pkg::U_W-1:0] u);
    logic signed [ppi_pkg::U_W-1:0] sh;
    logic [ppi_pkg::U_W-DW:0]       top;
    sh  = u >>> ppi_pkg::FRAC_BITS;
    top = sh[ppi_pkg::U_W-1:DW-1];
    if ((&top) || !(|top)) begin
      return sh[DW-1:0];
    end else if (sh[ppi_pkg::U_W-1]) begin
      return {1'b1, {(DW-1){1'b0}}};
    end else begin
      return {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  function automatic logic [DW-1:0] sat_point(input div_lane_t l);
    logic big;
    if (l.neg) begin
      big = l.ovf || l.q[DW] || (l.q[DW-1] && (|l.q[DW-2:0]));
      return big ? {1'b1, {(DW-1){1'b0}}} : DW'(-l.q);
    end else begin
      big = l.ovf || l.q[DW] || l.q[DW-1];
      return big ? {1'b0, {(DW-1){1'b1}}} : l.q[DW-1:0];
    end
  endfunction

  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[OUT_IDX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 1: the twelve input products.
  pair_t s1_u_r [3];
  pair_t s1_v_r [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_u_r[0].pa <= in_data.plane1_ny * in_data.plane2_nz;
      s1_u_r[0].pb <= in_data.plane1_nz * in_data.plane2_ny;
      s1_u_r[1].pa <= in_data.plane1_nz * in_data.plane2_nx;
      s1_u_r[1].pb <= in_data.plane1_nx * in_data.plane2_nz;
      s1_u_r[2].pa <= in_data.plane1_nx * in_data.plane2_ny;
      s1_u_r[2].pb <= in_data.plane1_ny * in_data.plane2_nx;
      s1_v_r[0].pa <= in_data.plane2_offset * in_data.plane1_nx;
      s1_v_r[0].pb <= in_data.plane1_offset * in_data.plane2_nx;
      s1_v_r[1].pa <= in_data.plane2_offset * in_data.plane1_ny;
      s1_v_r[1].pb <= in_data.plane1_offset * in_data.plane2_ny;
      s1_v_r[2].pa <= in_data.plane2_offset * in_data.plane1_nz;
      s1_v_r[2].pb <= in_data.plane1_offset * in_data.plane2_nz;
    end
  end

  // Stage 2: direction u and offset vector v, exact.
  logic signed [ppi_pkg::U_W-1:0] s2_u_r [3];
  logic signed [ppi_pkg::U_W-1:0] s2_v_r [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        s2_u_r[i] <= ppi_pkg::U_W'(s1_u_r[i].pa) - ppi_pkg::U_W'(s1_u_r[i].pb);
        s2_v_r[i] <= ppi_pkg::U_W'(s1_v_r[i].pa) - ppi_pkg::U_W'(s1_v_r[i].pb);
      end
    end
  end

  // Stage 3: magnitudes and signs, and the saturated direction.
  logic [ppi_pkg::MAG_W-1:0] s3_um_r [3];
  logic [ppi_pkg::MAG_W-1:0] s3_vm_r [3];
  logic [2:0]                s3_us_r;
  logic [2:0]                s3_vs_r;
  logic [2:0][DW-1:0]        s3_dir_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        s3_us_r[i]  <= s2_u_r[i][ppi_pkg::U_W-1];
        s3_vs_r[i]  <= s2_v_r[i][ppi_pkg::U_W-1];
        s3_um_r[i]  <= s2_u_r[i][ppi_pkg::U_W-1] ?
                       ppi_pkg::MAG_W'(-s2_u_r[i]) : ppi_pkg::MAG_W'(s2_u_r[i]);
        s3_vm_r[i]  <= s2_v_r[i][ppi_pkg::U_W-1] ?
                       ppi_pkg::MAG_W'(-s2_v_r[i]) : ppi_pkg::MAG_W'(s2_v_r[i]);
        s3_dir_r[i] <= sat_dir(s2_u_r[i]);
      end
    end
  end

  // Operands of the nine wide products: two per point term, then u squared.
  logic [ppi_pkg::MAG_W-1:0] opa [9];
  logic [ppi_pkg::MAG_W-1:0] opb [9];
  logic [8:0]                opsg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opa[2*i]   = s3_vm_r[(i+1)%3];
      opb[2*i]   = s3_um_r[(i+2)%3];
      opsg[2*i]  = s3_vs_r[(i+1)%3] ^ s3_us_r[(i+2)%3];
      opa[2*i+1] = s3_vm_r[(i+2)%3];
      opb[2*i+1] = s3_um_r[(i+1)%3];
      opsg[2*i+1] = s3_vs_r[(i+2)%3] ^ s3_us_r[(i+1)%3];
      opa[6+i]   = s3_um_r[i];
      opb[6+i]   = s3_um_r[i];
      opsg[6+i]  = 1'b0;
    end
  end

  // Stage 4: 32 by 32 partial products.
  logic [ppi_pkg::MAG_W-1:0] s4_pp_r [9][4];
  logic [8:0]                s4_sg_r;
  logic [2:0][DW-1:0]        s4_dir_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int p = 0; p < 9; p++) begin
        s4_pp_r[p][0] <= opa[p][ppi_pkg::HALF_W-1:0] * opb[p][ppi_pkg::HALF_W-1:0];
        s4_pp_r[p][1] <= opa[p][ppi_pkg::HALF_W-1:0] * opb[p][ppi_pkg::MAG_W-1:ppi_pkg::HALF_W];
        s4_pp_r[p][2] <= opa[p][ppi_pkg::MAG_W-1:ppi_pkg::HALF_W] * opb[p][ppi_pkg::HALF_W-1:0];
        s4_pp_r[p][3] <= opa[p][ppi_pkg::MAG_W-1:ppi_pkg::HALF_W] *
                         opb[p][ppi_pkg::MAG_W-1:ppi_pkg::HALF_W];
      end
      s4_sg_r  <= opsg;
      s4_dir_r <= s3_dir_r;
    end
  end

  // Stage 5: partial products summed into full magnitudes.
  logic [ppi_pkg::SQ_W-1:0] s5_mag_r [9];
  logic [8:0]               s5_sg_r;
  logic [2:0][DW-1:0]       s5_dir_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int p = 0; p < 9; p++) begin
        s5_mag_r[p] <= ppi_pkg::SQ_W'(s4_pp_r[p][0])
                     + (ppi_pkg::SQ_W'(s4_pp_r[p][1]) << ppi_pkg::HALF_W)
                     + (ppi_pkg::SQ_W'(s4_pp_r[p][2]) << ppi_pkg::HALF_W)
                     + (ppi_pkg::SQ_W'(s4_pp_r[p][3]) << ppi_pkg::MAG_W);
      end
      s5_sg_r  <= s4_sg_r;
      s5_dir_r <= s4_dir_r;
    end
  end

  // Stage 6: signs applied.
  logic signed [ppi_pkg::SP_W-1:0] s6_prod_r [9];
  logic [2:0][DW-1:0]              s6_dir_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int p = 0; p < 9; p++) begin
        s6_prod_r[p] <= s5_sg_r[p] ? -$signed({1'b0, s5_mag_r[p]})
                                   : $signed({1'b0, s5_mag_r[p]});
      end
      s6_dir_r <= s5_dir_r;
    end
  end

  // Stage 7: point numerator and squared length of u.
  logic signed [ppi_pkg::PN_W-1:0] s7_pn_r [3];
  logic [ppi_pkg::DEN_W-1:0]       s7_den_r;
  logic [2:0][DW-1:0]              s7_dir_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < 3; i++) begin
        s7_pn_r[i] <= ppi_pkg::PN_W'(s6_prod_r[2*i]) - ppi_pkg::PN_W'(s6_prod_r[2*i+1]);
      end
      s7_den_r <= ppi_pkg::DEN_W'(s6_prod_r[6][ppi_pkg::SQ_W-1:0])
                + ppi_pkg::DEN_W'(s6_prod_r[7][ppi_pkg::SQ_W-1:0])
                + ppi_pkg::DEN_W'(s6_prod_r[8][ppi_pkg::SQ_W-1:0]);
      s7_dir_r <= s6_dir_r;
    end
  end

  // Divider pipe: entry 0 takes the scaled numerator magnitudes, entry 1 the
  // overflow check, then one quotient bit per entry.
  div_stage_t div_r   [ppi_pkg::QBITS+2];
  div_stage_t div_nxt [ppi_pkg::QBITS+2];

  always_comb begin
    logic [ppi_pkg::REM_W-1:0] dsh;
    logic                      ge;
    dsh = '0;
    ge  = 1'b0;

    // Stage 8: scaled numerator magnitudes enter the divider.
    for (int i = 0; i < 3; i++) begin
      div_nxt[0].lane[i].neg = s7_pn_r[i][ppi_pkg::PN_W-1];
      div_nxt[0].lane[i].rem = ppi_pkg::REM_W'({(s7_pn_r[i][ppi_pkg::PN_W-1] ?
                                -s7_pn_r[i] : s7_pn_r[i]), {ppi_pkg::FRAC_BITS{1'b0}}});
      div_nxt[0].lane[i].q   = '0;
      div_nxt[0].lane[i].ovf = 1'b0;
    end
    div_nxt[0].den = s7_den_r;
    div_nxt[0].par = (s7_den_r == '0);
    div_nxt[0].dir = s7_dir_r;

    // Overflow check: a quotient of 2^33 or more saturates whatever its low bits.
    div_nxt[1] = div_r[0];
    for (int i = 0; i < 3; i++) begin
      div_nxt[1].lane[i].ovf = div_r[0].lane[i].rem >=
                               (ppi_pkg::REM_W'(div_r[0].den) << ppi_pkg::QBITS);
    end

    // Restoring divider, one quotient bit per stage, most significant first.
    for (int j = 1; j <= ppi_pkg::QBITS; j++) begin
      div_nxt[j+1] = div_r[j];
      dsh = ppi_pkg::REM_W'(div_r[j].den) << (ppi_pkg::QBITS - j);
      for (int i = 0; i < 3; i++) begin
        ge = div_r[j].lane[i].rem >= dsh;
        if (ge) begin
          div_nxt[j+1].lane[i].rem = div_r[j].lane[i].rem - dsh;
        end
        div_nxt[j+1].lane[i].q[ppi_pkg::QBITS - j] = ge;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ppi_pkg::QBITS + 2; k++) begin
      if (en[DIV_BASE - 1 + k]) begin
        div_r[k] <= div_nxt[k];
      end
    end
  end

  // Output register.
  ppi_pkg::ppi_out_t out_r;
  localparam int LAST = ppi_pkg::QBITS + 1;

  always_ff @(posedge clk) begin
    if (en[OUT_IDX]) begin
      out_r.line_dir_x      <= div_r[LAST].dir[0];
      out_r.line_dir_y      <= div_r[LAST].dir[1];
      out_r.line_dir_z      <= div_r[LAST].dir[2];
      out_r.line_point_x    <= div_r[LAST].par ? '0 : sat_point(div_r[LAST].lane[0]);
      out_r.line_point_y    <= div_r[LAST].par ? '0 : sat_point(div_r[LAST].lane[1]);
      out_r.line_point_z    <= div_r[LAST].par ? '0 : sat_point(div_r[LAST].lane[2]);
      out_r.planes_parallel <= div_r[LAST].par;
    end
  end

  assign out_data = out_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted transfer did not enter the first stage");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (vld_r == '1) && out_stall)
    else $error("input stalled while the pipeline has a free stage");

  a_parallel_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.planes_parallel) |->
      (out_data.line_point_x == '0) && (out_data.line_point_y == '0) &&
      (out_data.line_point_z == '0))
    else $error("parallel planes gave a nonzero point");

  a_parallel_dir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.planes_parallel) |->
      (out_data.line_dir_x == '0) && (out_data.line_dir_y == '0) &&
      (out_data.line_dir_z == '0))
    else $error("parallel planes gave a nonzero direction");

endmodule

// ===== sim/plane_plane_intersection_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plane-plane intersection core testbench
// Streams directed and random plane pairs through the core with random gaps
// and output stalls, and compares every line against an exact predictor.
// ----------------------------------------------------------------------------

class line_scoreboard;
  ppi_pkg::ppi_out_t expected_lines[$];
  int                mismatches;

  // Exact arithmetic in 256-bit signed vectors, as the core is specified.
  static function logic signed [255:0] ext(logic signed [ppi_pkg::DATA_WIDTH-1:0] v);
    logic signed [255:0] r;
    r = v;
    return r;
  endfunction

  static function logic signed [ppi_pkg::DATA_WIDTH-1:0] sat(logic signed [255:0] v);
    logic signed [255:0] hi, lo;
    hi = (256'sd1 <<< (ppi_pkg::DATA_WIDTH - 1)) - 1;
    lo = -(256'sd1 <<< (ppi_pkg::DATA_WIDTH - 1));
    if (v > hi) return hi[ppi_pkg::DATA_WIDTH-1:0];
    if (v < lo) return lo[ppi_pkg::DATA_WIDTH-1:0];
    return v[ppi_pkg::DATA_WIDTH-1:0];
  endfunction

  static function ppi_pkg::ppi_out_t predict_line(ppi_pkg::ppi_in_t p);
    logic signed [255:0] n1[3], n2[3], d1, d2, u[3], v[3], pn[3], den, num, q;
    ppi_pkg::ppi_out_t r;
    n1[0] = ext(p.plane1_nx); n1[1] = ext(p.plane1_ny); n1[2] = ext(p.plane1_nz);
    n2[0] = ext(p.plane2_nx); n2[1] = ext(p.plane2_ny); n2[2] = ext(p.plane2_nz);
    d1 = ext(p.plane1_offset);
    d2 = ext(p.plane2_offset);
    for (int i = 0; i < 3; i++) begin
      u[i] = n1[(i+1)%3] * n2[(i+2)%3] - n1[(i+2)%3] * n2[(i+1)%3];
      v[i] = d2 * n1[i] - d1 * n2[i];
    end
    den = 0;
    for (int i = 0; i < 3; i++) begin
      pn[i] = v[(i+1)%3] * u[(i+2)%3] - v[(i+2)%3] * u[(i+1)%3];
      den = den + u[i] * u[i];
    end
    r.line_dir_x = sat(u[0] >>> ppi_pkg::FRAC_BITS);
    r.line_dir_y = sat(u[1] >>> ppi_pkg::FRAC_BITS);
    r.line_dir_z = sat(u[2] >>> ppi_pkg::FRAC_BITS);
    r.planes_parallel = (den == 0);
    for (int i = 0; i < 3; i++) begin
      if (den == 0) begin
        q = 0;
      end else begin
        // Division truncates toward zero on signed operands.
        num = pn[i] <<< ppi_pkg::FRAC_BITS;
        q = num / den;
      end
      case (i)
        0: r.line_point_x = sat(q);
        1: r.line_point_y = sat(q);
        default: r.line_point_z = sat(q);
      endcase
    end
    return r;
  endfunction

  function void note_pair(ppi_pkg::ppi_in_t p);
    expected_lines.push_back(predict_line(p));
  endfunction

  task report(string what, logic signed [ppi_pkg::DATA_WIDTH-1:0] got,
              logic signed [ppi_pkg::DATA_WIDTH-1:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task check_line(ppi_pkg::ppi_out_t got);
    ppi_pkg::ppi_out_t want;
    if (expected_lines.size() == 0) begin
      report("unexpected transfer", got.line_dir_x, '0);
      return;
    end
    want = expected_lines.pop_front();
    if (got.line_dir_x !== want.line_dir_x) report("dir_x", got.line_dir_x, want.line_dir_x);
    if (got.line_dir_y !== want.line_dir_y) report("dir_y", got.line_dir_y, want.line_dir_y);
    if (got.line_dir_z !== want.line_dir_z) report("dir_z", got.line_dir_z, want.line_dir_z);
    if (got.line_point_x !== want.line_point_x)
      report("point_x", got.line_point_x, want.line_point_x);
    if (got.line_point_y !== want.line_point_y)
      report("point_y", got.line_point_y, want.line_point_y);
    if (got.line_point_z !== want.line_point_z)
      report("point_z", got.line_point_z, want.line_point_z);
    if (got.planes_parallel !== want.planes_parallel)
      report("parallel", got.planes_parallel, want.planes_parallel);
  endtask
endclass

module plane_plane_intersection_core_test;
  localparam int RANDOM_PAIRS = 1330;
  localparam int DRAIN_CYCLES = 60;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  ppi_pkg::ppi_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  ppi_pkg::ppi_out_t out_data;

  line_scoreboard lines = new();
  bit       sending_done = 1'b0;
  bit       long_hold = 1'b0;

  plane_plane_intersection_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // Neither side inserts random gaps or hold-offs while quiet is set.
  bit quiet = 1'b0;

  task automatic send_pair(ppi_pkg::ppi_in_t p);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    lines.note_pair(p);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 | $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $signed($urandom_range(0, 8)) <<< 16;
      3: return 32'(signed'($urandom_range(0, 1024)) - 512);
      default: return $urandom();
    endcase
  endfunction

  function automatic ppi_pkg::ppi_in_t rand_pair();
    ppi_pkg::ppi_in_t p;
    p = {rand_word(), rand_word(), rand_word(), rand_word(),
         rand_word(), rand_word(), rand_word(), rand_word()};
    // Some pairs get parallel or identical normals, others small first-plane normals.
    case ($urandom_range(0, 9))
      0: begin
        p.plane2_nx = p.plane1_nx; p.plane2_ny = p.plane1_ny; p.plane2_nz = p.plane1_nz;
      end
      1: begin
        p.plane2_nx = -p.plane1_nx; p.plane2_ny = -p.plane1_ny; p.plane2_nz = -p.plane1_nz;
      end
      2: begin
        p.plane1_nx = 32'(signed'($urandom_range(0, 64)) - 32);
        p.plane1_ny = 32'(signed'($urandom_range(0, 64)) - 32);
        p.plane1_nz = 32'(signed'($urandom_range(0, 64)) - 32);
      end
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    localparam logic [31:0] MX = 32'h7FFF_FFFF, MN = 32'h8000_0000, ONE = 32'h0001_0000;
    ppi_pkg::ppi_in_t directed[$];
    directed.push_back('0);
    directed.push_back({ONE, 32'd0, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0});
    directed.push_back({ONE, 32'd0, 32'd0, ONE, 32'd0, ONE, 32'd0, -ONE});
    directed.push_back({ONE, ONE, 32'd0, ONE, 32'h2_0000, 32'h2_0000, 32'd0, -ONE});
    directed.push_back({MX, MX, MX, MX, MN, MN, MN, MN});
    directed.push_back({MN, MN, MN, MN, MN, MN, MN, MN});
    directed.push_back({MX, 32'd0, 32'd0, MX, 32'd0, MX, 32'd0, MN});
    directed.push_back({MN, 32'd0, 32'd0, MN, 32'd0, MN, 32'd0, MX});
    directed.push_back({MN, MX, 32'd0, MX, MX, MN, MX, MN});
    directed.push_back({32'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0});
    directed.push_back({32'd1, 32'd0, 32'd0, MX, 32'd0, 32'd1, 32'd0, MN});
    directed.push_back({32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, MX});
    directed.push_back({MX, MX, 32'd1, MX, MX, MX, 32'd0, MN});
    directed.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0});
    directed.push_back({ONE, ONE, ONE, MX, -ONE, -ONE, -ONE, MN});
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    quiet = 1'b1;
    foreach (directed[i]) send_pair(directed[i]);
    quiet = 1'b0;
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i == 300) long_hold = 1'b1;
      quiet = (i >= 700 && i < 800);
      send_pair(rand_pair());
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: a random hold-off before every transfer outside quiet stretches, and
  // one long hold-off while the sender keeps going.
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
      end
      hold = quiet ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) lines.check_line(out_data);
  end

  initial begin
    wait (sending_done);
    while (lines.expected_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lines.mismatches == 0) begin
      $display("PASS plane_plane_intersection_core");
    end else begin
      $display("FAIL plane_plane_intersection_core");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("FAIL plane_plane_intersection_core");
    $finish;
  end
endmodule
